// File: hw/rtl/crcpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcpd_pkg: shared types and constants of the packet deframer
// CRC-16 CCITT byte update, event codes, header window type and result word.
// ----------------------------------------------------------------------------
package crcpd_pkg;

  localparam int unsigned HDR_LEN   = 9;
  localparam int unsigned FILL_W    = 4;
  localparam logic [7:0]  MAGIC_BYTE = 8'h50;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [6:0]  CMD_RESET  = 7'd6;

  // header window byte positions
  localparam int unsigned POS_MAGIC = 0;
  localparam int unsigned POS_SIZE  = 1;
  localparam int unsigned POS_SRC   = 2;
  localparam int unsigned POS_DST   = 3;
  localparam int unsigned POS_ID    = 4;
  localparam int unsigned POS_HCRC  = 5;
  localparam int unsigned POS_PCRC  = 7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_KIND       = 2'd2;

  typedef enum logic [2:0] {
    EV_PAYLOAD   = 3'd0,
    EV_GOOD      = 3'd1,
    EV_BAD_MAGIC = 3'd2,
    EV_BAD_HCRC  = 3'd3,
    EV_BAD_PCRC  = 3'd4
  } event_kind_t;

  typedef logic [HDR_LEN-1:0][7:0] window_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  source_node;
    logic [7:0]  dest_node;
    logic [7:0]  packet_kind;
    logic [7:0]  length;
    logic        for_this_node;
    logic        reset_request;
    logic        unknown_command;
  } result_t;

  // reflected ccitt update, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ c[7:0];
    d = d ^ {d[3:0], 4'b0000};
    crc_step = {d, c[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/crcpd_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcpd_in_reg: input byte register
// Holds one received word until the core consumes it.
// ----------------------------------------------------------------------------
module crcpd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       consume,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  assign in_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (consume) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/crcpd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcpd_core: deframer state and per-byte decision logic
// Header window, payload counter and running crc; one byte per step.
// ----------------------------------------------------------------------------
module crcpd_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [7:0]      own_address,
  input  wire logic [7:0]      broadcast_address,
  input  wire logic [7:0]      system_payload_kind,
  output logic                 res_valid,
  output crcpd_pkg::result_t   res
);

  crcpd_pkg::window_t                 window, window_next;
  logic [crcpd_pkg::FILL_W-1:0]       window_fill, window_fill_next;
  logic                               in_payload, in_payload_next;
  logic [7:0]                         payload_count, payload_count_next;
  logic [15:0]                        running_crc, running_crc_next;
  logic [7:0]                         first_payload, first_payload_next;

  crcpd_pkg::window_t  win_with_byte;
  crcpd_pkg::window_t  win_shift_old;
  crcpd_pkg::window_t  win_shift_new;
  logic [15:0]         hdr_crc;
  logic [15:0]         pay_crc;
  logic [7:0]          count_inc;
  logic [7:0]          fp_upd;
  logic                window_full;
  logic                emit_good;
  logic                mine;
  logic                sys_cmd;
  logic [7:0]          fp_emit;
  crcpd_pkg::event_kind_t ev;
  logic [7:0]          ev_data;
  logic [7:0]          ev_index;

  // window with the new byte at the fill position, and the drop-one shifts
  always_comb begin
    for (int k = 0; k < crcpd_pkg::HDR_LEN; k++) begin
      win_with_byte[k] = (window_fill == crcpd_pkg::FILL_W'(k)) ? rx_byte : window[k];
    end
    for (int k = 0; k < crcpd_pkg::HDR_LEN - 1; k++) begin
      win_shift_old[k] = window[k+1];
      win_shift_new[k] = win_with_byte[k+1];
    end
    win_shift_old[crcpd_pkg::HDR_LEN-1] = window[crcpd_pkg::HDR_LEN-1];
    win_shift_new[crcpd_pkg::HDR_LEN-1] = win_with_byte[crcpd_pkg::HDR_LEN-1];
  end

  // header crc over the five leading bytes, already held when the window completes
  always_comb begin
    hdr_crc = crcpd_pkg::CRC_INIT;
    for (int k = 0; k < 5; k++) begin
      hdr_crc = crcpd_pkg::crc_step(hdr_crc, window[k]);
    end
  end

  assign pay_crc     = crcpd_pkg::crc_step(running_crc, rx_byte);
  assign count_inc   = payload_count + 8'd1;
  assign fp_upd      = (payload_count == 8'd0) ? rx_byte : first_payload;
  assign window_full = (window_fill == crcpd_pkg::FILL_W'(crcpd_pkg::HDR_LEN - 1));

  always_comb begin
    window_next        = window;
    window_fill_next   = window_fill;
    in_payload_next    = in_payload;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    first_payload_next = first_payload;
    res_valid          = 1'b0;
    emit_good          = 1'b0;
    fp_emit            = first_payload;
    ev                 = crcpd_pkg::EV_PAYLOAD;
    ev_data            = 8'd0;
    ev_index           = 8'd0;

    if (in_payload) begin
      running_crc_next   = pay_crc;
      payload_count_next = count_inc;
      first_payload_next = fp_upd;
      fp_emit            = fp_upd;
      res_valid          = 1'b1;
      if (count_inc == window[crcpd_pkg::POS_SIZE]) begin
        in_payload_next = 1'b0;
        if (pay_crc == {window[crcpd_pkg::POS_PCRC+1], window[crcpd_pkg::POS_PCRC]}) begin
          ev               = crcpd_pkg::EV_GOOD;
          emit_good        = 1'b1;
          window_fill_next = '0;
        end else begin
          ev               = crcpd_pkg::EV_BAD_PCRC;
          window_next      = win_shift_old;
          window_fill_next = crcpd_pkg::FILL_W'(crcpd_pkg::HDR_LEN - 1);
        end
      end else begin
        ev       = crcpd_pkg::EV_PAYLOAD;
        ev_data  = rx_byte;
        ev_index = payload_count;
      end
    end else if (!window_full) begin
      window_next      = win_with_byte;
      window_fill_next = window_fill + crcpd_pkg::FILL_W'(1);
    end else if (window[crcpd_pkg::POS_MAGIC] != crcpd_pkg::MAGIC_BYTE) begin
      res_valid        = 1'b1;
      ev               = crcpd_pkg::EV_BAD_MAGIC;
      window_next      = win_shift_new;
      window_fill_next = crcpd_pkg::FILL_W'(crcpd_pkg::HDR_LEN - 1);
    end else if (hdr_crc != {window[crcpd_pkg::POS_HCRC+1], window[crcpd_pkg::POS_HCRC]}) begin
      res_valid        = 1'b1;
      ev               = crcpd_pkg::EV_BAD_HCRC;
      window_next      = win_shift_new;
      window_fill_next = crcpd_pkg::FILL_W'(crcpd_pkg::HDR_LEN - 1);
    end else begin
      // header accepted
      first_payload_next = 8'd0;
      fp_emit            = 8'd0;
      payload_count_next = 8'd0;
      running_crc_next   = crcpd_pkg::CRC_INIT;
      if (window[crcpd_pkg::POS_SIZE] == 8'd0) begin
        // empty payload: stored crc must equal the initial value
        res_valid = 1'b1;
        if ({rx_byte, window[crcpd_pkg::POS_PCRC]} == crcpd_pkg::CRC_INIT) begin
          ev               = crcpd_pkg::EV_GOOD;
          emit_good        = 1'b1;
          window_next      = win_with_byte;
          window_fill_next = '0;
        end else begin
          ev               = crcpd_pkg::EV_BAD_PCRC;
          window_next      = win_shift_new;
          window_fill_next = crcpd_pkg::FILL_W'(crcpd_pkg::HDR_LEN - 1);
        end
      end else begin
        in_payload_next  = 1'b1;
        window_next      = win_with_byte;
        window_fill_next = crcpd_pkg::FILL_W'(crcpd_pkg::HDR_LEN);
      end
    end
  end

  // header-derived result fields never depend on the byte being stored
  assign mine = (window[crcpd_pkg::POS_DST] == own_address) ||
                (window[crcpd_pkg::POS_DST] == broadcast_address);
  assign sys_cmd = emit_good && mine &&
                   (window[crcpd_pkg::POS_ID] == system_payload_kind) &&
                   (window[crcpd_pkg::POS_SIZE] != 8'd0);

  always_comb begin
    res.event_kind      = ev;
    res.data_byte       = ev_data;
    res.byte_index      = ev_index;
    res.source_node     = window[crcpd_pkg::POS_SRC];
    res.dest_node       = window[crcpd_pkg::POS_DST];
    res.packet_kind     = window[crcpd_pkg::POS_ID];
    res.length          = window[crcpd_pkg::POS_SIZE];
    res.for_this_node   = mine;
    res.reset_request   = sys_cmd && (fp_emit[6:0] == crcpd_pkg::CMD_RESET);
    res.unknown_command = sys_cmd && (fp_emit[6:0] != crcpd_pkg::CMD_RESET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      window_fill   <= '0;
      in_payload    <= 1'b0;
      payload_count <= 8'd0;
      running_crc   <= crcpd_pkg::CRC_INIT;
      first_payload <= 8'd0;
    end else if (step) begin
      window        <= window_next;
      window_fill   <= window_fill_next;
      in_payload    <= in_payload_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      first_payload <= first_payload_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/crcpd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcpd_out_reg: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module crcpd_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire crcpd_pkg::result_t  load_res,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output crcpd_pkg::result_t       out_res,
  output logic                     slot_free
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/crc_checked_packet_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer: crc-16 ccitt framed packet receiver
// a byte waits in the input register, its result word in the output register
// throughput: one byte per cycle unless the result side stalls
// a byte that gives no result still passes through the input register
// reset (synchronous, rst high) empties both registers, clears the window
// and loads the registers with own 0, broadcast 255, system kind 0
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                           // [23:16] source_node, [31:24] dest_node,
                                           // [39:32] packet_kind, [47:40] length,
                                           // [48] for_this_node, [49] reset_request,
                                           // [50] unknown_command, [55:51] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] event_kind
  // configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [crcpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // configuration registers
  logic [7:0] own_address;
  logic [7:0] broadcast_address;
  logic [7:0] system_payload_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address         <= 8'd0;
      broadcast_address   <= 8'hFF;
      system_payload_kind <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        crcpd_pkg::CFG_OWN_ADDRESS:       own_address         <= cfg_data;
        crcpd_pkg::CFG_BROADCAST_ADDRESS: broadcast_address   <= cfg_data;
        crcpd_pkg::CFG_SYSTEM_KIND:       system_payload_kind <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // pipeline glue
  logic               held_valid;
  logic [7:0]         held_byte;
  logic               step;
  logic               res_valid;
  logic               slot_free;
  crcpd_pkg::result_t core_res;
  crcpd_pkg::result_t out_res;

  // the core steps only when the output register can take whatever comes out,
  // so no result is lost; bytes that give no result wait on the same condition
  assign step = held_valid && slot_free;

  crcpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .consume    (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  crcpd_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .rx_byte             (held_byte),
    .own_address         (own_address),
    .broadcast_address   (broadcast_address),
    .system_payload_kind (system_payload_kind),
    .res_valid           (res_valid),
    .res                 (core_res)
  );

  crcpd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_res  (core_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .slot_free (slot_free)
  );

  // result word packing, lowest field first
  assign m_axis_tuser = out_res.event_kind;
  assign m_axis_tdata = {5'b0,
                         out_res.unknown_command,
                         out_res.reset_request,
                         out_res.for_this_node,
                         out_res.length,
                         out_res.packet_kind,
                         out_res.dest_node,
                         out_res.source_node,
                         out_res.byte_index,
                         out_res.data_byte};

  // checks

  // only payload words carry a data byte and an index
  a_status_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != crcpd_pkg::EV_PAYLOAD)) |->
      (m_axis_tdata[15:0] == 16'd0))
    else $error("status word carries payload data");

  // command flags only on a good packet for this node, never both
  a_cmd_flags: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[49] || m_axis_tdata[50])) |->
      ((m_axis_tuser == crcpd_pkg::EV_GOOD) && m_axis_tdata[48] &&
       !(m_axis_tdata[49] && m_axis_tdata[50])))
    else $error("command flag on a word that is not a good addressed packet");

  // a held byte with a stalled result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (held_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the held byte cannot advance");

endmodule
`default_nettype wire

// File: tb/sv/crc_checked_packet_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer_test: self-checking bench for the packet deframer
// Streams well-formed, corrupted and noisy byte frames into the block, predicts
// every result word from an independent copy of the header window and crc
// state, and compares the words field by field under several address
// settings and idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer_test;
  import crcpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;  // no register behind it
  localparam int unsigned PHASE_ITEMS   = 90;   // random bytes per phase, roughly
  localparam int unsigned HOLD_CYCLES   = 60;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;    // drain margin after the last predicted word

  typedef enum {FLAW_NONE, FLAW_MAGIC, FLAW_HCRC, FLAW_PCRC} flaw_t;

  // tracks the deframer state and holds the words still to come
  class deframe_checker;
    logic [7:0]  node_addr, bcast_addr, sys_kind;
    logic [7:0]  hdr [HDR_LEN];
    int unsigned fill;
    bit          taking_payload;
    logic [7:0]  taken;
    logic [15:0] pay_crc;
    logic [7:0]  cmd_byte;
    result_t     pending_events [$];
    int unsigned errors;

    function new();
      node_addr  = 8'h00;
      bcast_addr = 8'hFF;
      sys_kind   = 8'h00;
      foreach (hdr[k]) hdr[k] = 8'h00;
      fill           = 0;
      taking_payload = 1'b0;
      taken          = 8'h00;
      pay_crc        = CRC_INIT;
      cmd_byte       = 8'h00;
      errors         = 0;
    endfunction

    // bit-serial form of the reflected ccitt polynomial
    static function logic [15:0] ccitt_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
      return r;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_OWN_ADDRESS:       node_addr  = v;
        CFG_BROADCAST_ADDRESS: bcast_addr = v;
        CFG_SYSTEM_KIND:       sys_kind   = v;
        default: ;
      endcase
    endfunction

    function void emit_event(event_kind_t kind, logic [7:0] data, logic [7:0] idx, bit good);
      result_t r;
      bit      is_sys;
      r.event_kind    = kind;
      r.data_byte     = data;
      r.byte_index    = idx;
      r.source_node   = hdr[POS_SRC];
      r.dest_node     = hdr[POS_DST];
      r.packet_kind   = hdr[POS_ID];
      r.length        = hdr[POS_SIZE];
      r.for_this_node = (hdr[POS_DST] == node_addr) || (hdr[POS_DST] == bcast_addr);
      is_sys = good && r.for_this_node && hdr[POS_ID] == sys_kind && hdr[POS_SIZE] != 8'h00;
      r.reset_request   = is_sys && cmd_byte[6:0] == CMD_RESET;
      r.unknown_command = is_sys && !r.reset_request;
      pending_events.push_back(r);
    endfunction

    function void drop_oldest();
      for (int k = 0; k < HDR_LEN - 1; k++) hdr[k] = hdr[k + 1];
      fill = HDR_LEN - 1;
    endfunction

    function void close_packet(logic [15:0] crc);
      taking_payload = 1'b0;
      if (crc == {hdr[POS_PCRC + 1], hdr[POS_PCRC]}) begin
        emit_event(EV_GOOD, 8'h00, 8'h00, 1'b1);
        fill = 0;
      end else begin
        emit_event(EV_BAD_PCRC, 8'h00, 8'h00, 1'b0);
        drop_oldest();
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] c;
      logic [7:0]  idx;
      if (taking_payload) begin
        idx     = taken;
        pay_crc = ccitt_update(pay_crc, b);
        if (idx == 8'h00) cmd_byte = b;
        taken = idx + 8'd1;
        if (taken == hdr[POS_SIZE]) close_packet(pay_crc);
        else emit_event(EV_PAYLOAD, b, idx, 1'b0);
        return;
      end
      if (fill >= HDR_LEN) fill = HDR_LEN - 1;
      hdr[fill] = b;
      fill++;
      if (fill < HDR_LEN) return;
      if (hdr[POS_MAGIC] != MAGIC_BYTE) begin
        emit_event(EV_BAD_MAGIC, 8'h00, 8'h00, 1'b0);
        drop_oldest();
        return;
      end
      c = CRC_INIT;
      for (int k = 0; k < POS_HCRC; k++) c = ccitt_update(c, hdr[k]);
      if (c != {hdr[POS_HCRC + 1], hdr[POS_HCRC]}) begin
        emit_event(EV_BAD_HCRC, 8'h00, 8'h00, 1'b0);
        drop_oldest();
        return;
      end
      cmd_byte = 8'h00;
      taken    = 8'h00;
      pay_crc  = CRC_INIT;
      if (hdr[POS_SIZE] == 8'h00) close_packet(CRC_INIT);
      else taking_payload = 1'b1;
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    function void match_result(logic [55:0] word, logic [2:0] kind);
      result_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected word, expected none, got event %0h data %0h",
                 $time, kind, word);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (kind       !== want.event_kind)      flag("event_kind", want.event_kind, kind);
      if (word[7:0]  !== want.data_byte)       flag("data_byte", want.data_byte, word[7:0]);
      if (word[15:8] !== want.byte_index)      flag("byte_index", want.byte_index, word[15:8]);
      if (word[23:16] !== want.source_node)    flag("source_node", want.source_node, word[23:16]);
      if (word[31:24] !== want.dest_node)      flag("dest_node", want.dest_node, word[31:24]);
      if (word[39:32] !== want.packet_kind)    flag("packet_kind", want.packet_kind, word[39:32]);
      if (word[47:40] !== want.length)         flag("length", want.length, word[47:40]);
      if (word[48] !== want.for_this_node)     flag("for_this_node", want.for_this_node, word[48]);
      if (word[49] !== want.reset_request)     flag("reset_request", want.reset_request, word[49]);
      if (word[50] !== want.unknown_command)   flag("unknown_command", want.unknown_command, word[50]);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;    // [7:0] rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [55:0]          m_axis_tdata;    // [7:0] data_byte ... [50] unknown_command
  logic [2:0]           m_axis_tuser;    // [2:0] event_kind
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  deframe_checker track;

  // idle and stall odds in percent, changed between phases
  int unsigned send_idle;
  int unsigned rx_stall;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int unsigned hold_ticket;
  int unsigned bytes_sent;

  crc_checked_packet_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("** crc_checked_packet_deframer: FAILED **");
    $finish;
  end

  // result side: check each accepted word, then pick the next ready value
  initial begin
    int unsigned served;
    int unsigned hold_left;
    served    = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      // values seen here are the ones from just before the edge
      if (!rst && m_axis_tvalid && m_axis_tready) track.match_result(m_axis_tdata, m_axis_tuser);
      if (served != hold_ticket) begin
        served    = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  // offer one byte, with random idle cycles first, and wait for the handshake
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    track.take_byte(b);
    bytes_sent++;
  endtask

  // stop sending, wait for every predicted word, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (track.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers plus the unused index, only while the block is idle
  task automatic program_regs(input logic [7:0] own, input logic [7:0] bcast,
                              input logic [7:0] kind);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [7:0]           val [4];
    idx = '{CFG_OWN_ADDRESS, CFG_BROADCAST_ADDRESS, CFG_SYSTEM_KIND, CFG_SPARE_INDEX};
    val = '{own, bcast, kind, 8'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      track.set_reg(idx[k], val[k]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // header, both crcs little-endian, then the payload; one flaw at most
  task automatic send_frame(input logic [7:0] size, input logic [7:0] src,
                            input logic [7:0] dst, input logic [7:0] id,
                            input logic [7:0] first, input flaw_t flaw);
    logic [7:0]  body [$];
    logic [7:0]  head [5];
    logic [15:0] hc;
    logic [15:0] pc;
    body = {};
    pc   = CRC_INIT;
    for (int k = 0; k < size; k++) begin
      body.push_back(k == 0 ? first : 8'($urandom));
      pc = deframe_checker::ccitt_update(pc, body[k]);
    end
    head = '{MAGIC_BYTE, size, src, dst, id};
    hc   = CRC_INIT;
    foreach (head[k]) hc = deframe_checker::ccitt_update(hc, head[k]);
    case (flaw)
      FLAW_MAGIC: head[POS_MAGIC] = MAGIC_BYTE ^ 8'($urandom_range(1, 255));
      FLAW_HCRC:  hc = hc ^ (16'h0001 << $urandom_range(15));
      FLAW_PCRC:  pc = pc ^ (16'h0001 << $urandom_range(15));
      default: ;
    endcase
    foreach (head[k]) send_byte(head[k]);
    send_byte(hc[7:0]);
    send_byte(hc[15:8]);
    send_byte(pc[7:0]);
    send_byte(pc[15:8]);
    foreach (body[k]) send_byte(body[k]);
  endtask

  // mostly well-formed frames with random content, some broken, some noise
  task automatic random_frame();
    int unsigned pick;
    int unsigned size_pick;
    logic [7:0]  size;
    logic [7:0]  dst;
    logic [7:0]  id;
    logic [7:0]  first;
    flaw_t       flaw;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // line noise, which the block has to scan through byte by byte
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      return;
    end
    flaw = pick < 16 ? FLAW_MAGIC : pick < 26 ? FLAW_HCRC : pick < 36 ? FLAW_PCRC : FLAW_NONE;
    // small payloads mostly, empty ones often, a rare large one of 128 to 255 bytes
    size_pick = $urandom_range(99);
    size = size_pick < 70 ? 8'($urandom_range(4)) :
           size_pick < 99 ? 8'($urandom_range(5, 24)) : 8'($urandom_range(128, 255));
    case ($urandom_range(2))
      0: dst = track.node_addr;
      1: dst = track.bcast_addr;
      default: dst = 8'($urandom);
    endcase
    id = $urandom_range(1) ? track.sys_kind : 8'($urandom);
    // reset command with either top bit, or any other command value
    first = $urandom_range(1) ? {1'($urandom), CMD_RESET} : 8'($urandom);
    send_frame(size, 8'($urandom), dst, id, first, flaw);
  endtask

  initial begin
    int unsigned phase_start;
    logic [7:0]  shared;
    track = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_OWN_ADDRESS;
    cfg_data      <= 8'h00;
    send_idle   = 0;
    rx_stall    = 0;
    hold_ticket = 0;
    bytes_sent  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    // good empty frame to broadcast with the system id: status only, no command
    send_frame(8'd0, 8'h00, 8'hFF, 8'h00, 8'h00, FLAW_NONE);
    // reset command with the top bit set, to our own address
    send_frame(8'd2, 8'hFF, 8'h00, 8'h00, 8'h86, FLAW_NONE);
    // bad header crc, then one byte that completes the window with the zero size byte in the magic slot
    send_frame(8'd0, 8'h5A, 8'h00, 8'hFF, 8'h00, FLAW_HCRC);
    send_byte(8'hFF);
    settle();

    // longest payload while the receiver holds off: the block must stall input
    hold_ticket++;
    send_frame(8'd255, 8'h3C, track.node_addr, track.sys_kind, 8'h06, FLAW_NONE);
    // sender waits for every word before going on
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle = 0;
          rx_stall  = 0;
        end
        1: begin
          program_regs(8'hFF, 8'h00, 8'hFF);
          send_idle = 75;
          rx_stall  = 0;
        end
        2: begin
          program_regs(8'($urandom), 8'($urandom), 8'($urandom));
          send_idle = 0;
          rx_stall  = 75;
        end
        default: begin
          // own and broadcast address the same
          shared = 8'($urandom);
          program_regs(shared, shared, 8'($urandom));
          send_idle = 15;
          rx_stall  = 15;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) random_frame();
      settle();
    end

    if (track.errors == 0) begin
      $display("** crc_checked_packet_deframer: PASSED **");
    end else begin
      $display("** crc_checked_packet_deframer: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/crcpd_pkg.sv
hw/rtl/crcpd_in_reg.sv
hw/rtl/crcpd_core.sv
hw/rtl/crcpd_out_reg.sv
hw/rtl/crc_checked_packet_deframer.sv
tb/sv/crc_checked_packet_deframer_test.sv
